[hdl/suffix_automaton_distinct_substrings_defines.svh]
// assertion macros for the suffix automaton block
// no dependencies; included by the top level only
`ifndef SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_DEFINES_SVH
`define SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_DEFINES_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define SAD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication into the next cycle
`define SAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SAD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SAD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/sad_pkg.sv]
// shared constants, operation codes and controller/datapath types
// no dependencies
package sad_pkg;
   localparam int MAX_LEN_DEF  = 1024;
   localparam int ALPHABET_DEF = 26;
   localparam int SYM_W   = 5;
   localparam int TOTAL_W = 20;
   localparam int NEW_W   = 11;
   localparam int OP_W    = 5;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT     = 5'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_INIT = 5'd2;
   localparam logic [OP_W-1:0] OP_ROW_CLR    = 5'd3;
   localparam logic [OP_W-1:0] OP_NEW_STATE  = 5'd4;
   localparam logic [OP_W-1:0] OP_LLP        = 5'd5;
   localparam logic [OP_W-1:0] OP_WALK_RD    = 5'd6;
   localparam logic [OP_W-1:0] OP_WALK1_CK   = 5'd7;
   localparam logic [OP_W-1:0] OP_Q_RD       = 5'd8;
   localparam logic [OP_W-1:0] OP_Q_CK       = 5'd9;
   localparam logic [OP_W-1:0] OP_COPY       = 5'd10;
   localparam logic [OP_W-1:0] OP_LINKQ      = 5'd11;
   localparam logic [OP_W-1:0] OP_LINKCUR    = 5'd12;
   localparam logic [OP_W-1:0] OP_WALK2_CK   = 5'd13;
   localparam logic [OP_W-1:0] OP_FIN_RD     = 5'd14;
   localparam logic [OP_W-1:0] OP_FIN_CK     = 5'd15;
   localparam logic [OP_W-1:0] OP_OUT        = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } sad_cmd_type;

   typedef struct packed {
      logic mode;
      logic sym_ok;
      logic full;
      logic t_zero;
      logic lk_zero;
      logic ll_match;
      logic t_eq_q;
      logic idx_last;
      logic rsp_free;
   } sad_status_type;
endpackage

[hdl/sad_ctrl.sv]
// controller state machine: sequences the automaton update steps
// depends on sad_pkg
module sad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sad_pkg::sad_status_type status,
   output sad_pkg::sad_cmd_type    cmd
);
   import sad_pkg::*;

   localparam logic [4:0] ST_CLRI = 5'd0;
   localparam logic [4:0] ST_RCLR = 5'd1;
   localparam logic [4:0] ST_IDLE = 5'd2;
   localparam logic [4:0] ST_DISP = 5'd3;
   localparam logic [4:0] ST_NEW  = 5'd4;
   localparam logic [4:0] ST_LLP  = 5'd5;
   localparam logic [4:0] ST_NROW = 5'd6;
   localparam logic [4:0] ST_W1RD = 5'd7;
   localparam logic [4:0] ST_W1CK = 5'd8;
   localparam logic [4:0] ST_QRD  = 5'd9;
   localparam logic [4:0] ST_QCK  = 5'd10;
   localparam logic [4:0] ST_COPY = 5'd11;
   localparam logic [4:0] ST_CPND = 5'd12;
   localparam logic [4:0] ST_LNKQ = 5'd13;
   localparam logic [4:0] ST_LNKC = 5'd14;
   localparam logic [4:0] ST_W2RD = 5'd15;
   localparam logic [4:0] ST_W2CK = 5'd16;
   localparam logic [4:0] ST_FRD  = 5'd17;
   localparam logic [4:0] ST_FCK  = 5'd18;
   localparam logic [4:0] ST_OUT  = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       reply_ff, reply_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_CLRI: begin
            cmd.op   = OP_CLEAR_INIT;
            state_in = ST_RCLR;
         end
         ST_RCLR: begin
            cmd.op = OP_ROW_CLR;
            if (status.idx_last) begin
               state_in = reply_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               reply_in = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            if (status.mode) begin
               state_in = ST_CLRI;
            end else if (!status.sym_ok || status.full) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_NEW;
            end
         end
         ST_NEW: begin
            cmd.op   = OP_NEW_STATE;
            state_in = ST_LLP;
         end
         ST_LLP: begin
            cmd.op   = OP_LLP;
            state_in = ST_NROW;
         end
         ST_NROW: begin
            cmd.op = OP_ROW_CLR;
            if (status.idx_last) begin
               state_in = ST_W1RD;
            end
         end
         ST_W1RD: begin
            cmd.op   = OP_WALK_RD;
            state_in = ST_W1CK;
         end
         ST_W1CK: begin
            cmd.op = OP_WALK1_CK;
            if (!status.t_zero) begin
               state_in = ST_QRD;
            end else if (status.lk_zero) begin
               state_in = ST_FRD;
            end else begin
               state_in = ST_W1RD;
            end
         end
         ST_QRD: begin
            cmd.op   = OP_Q_RD;
            state_in = ST_QCK;
         end
         ST_QCK: begin
            cmd.op   = OP_Q_CK;
            state_in = status.ll_match ? ST_FRD : ST_COPY;
         end
         ST_COPY: begin
            cmd.op = OP_COPY;
            if (status.idx_last) begin
               state_in = ST_CPND;
            end
         end
         ST_CPND: begin
            state_in = ST_LNKQ;
         end
         ST_LNKQ: begin
            cmd.op   = OP_LINKQ;
            state_in = ST_LNKC;
         end
         ST_LNKC: begin
            cmd.op   = OP_LINKCUR;
            state_in = ST_W2RD;
         end
         ST_W2RD: begin
            cmd.op   = OP_WALK_RD;
            state_in = ST_W2CK;
         end
         ST_W2CK: begin
            cmd.op = OP_WALK2_CK;
            if (status.t_eq_q && !status.lk_zero) begin
               state_in = ST_W2RD;
            end else begin
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            cmd.op   = OP_FIN_RD;
            state_in = ST_FCK;
         end
         ST_FCK: begin
            cmd.op   = OP_FIN_CK;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.op   = OP_OUT;
               reply_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLRI;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLRI;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end
endmodule

[hdl/sad_datapath.sv]
// datapath: transition, length and link memories, walk registers, counters
// depends on sad_pkg
module sad_datapath #(
   parameter int MAX_LEN  = sad_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = sad_pkg::ALPHABET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sad_pkg::sad_cmd_type         cmd,
   output sad_pkg::sad_status_type      status,
   input  logic                         req_mode,
   input  logic [sad_pkg::SYM_W-1:0]    req_symbol,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [sad_pkg::TOTAL_W-1:0]  rsp_total,
   output logic [sad_pkg::NEW_W-1:0]    rsp_new,
   output logic [sad_pkg::TOTAL_W-1:0]  rsp_ending,
   output logic                         rsp_full
);
   import sad_pkg::*;

   localparam int NSTATES = 2 * MAX_LEN + 2;
   localparam int SW      = $clog2(2 * MAX_LEN);
   localparam int PW      = $clog2(MAX_LEN + 1);
   localparam int SYMW    = $clog2(ALPHABET);
   localparam int AW      = SW + SYMW;

   // memories
   logic [SW-1:0] trans_mem [2**AW];
   logic [PW-1:0] ll_mem    [2**SW];
   logic [SW-1:0] lk_mem    [2**SW];

   logic [SW-1:0] trans_rd_ff, lk_rd_ff;
   logic [PW-1:0] ll_rd_ff;

   logic [AW-1:0] trans_ra, trans_wa;
   logic [SW-1:0] trans_wd, ll_ra, ll_wa, lk_ra, lk_wa, lk_wd;
   logic [PW-1:0] ll_wd;
   logic          trans_we, ll_we, lk_we;

   // walk and bookkeeping registers
   logic [SW-1:0]   p_ff, cur_ff, q_ff, clone_ff, sc_ff, last_ff, row_ff, lnkcur_ff;
   logic [PW-1:0]   llp_ff, llcur_ff, plen_ff, added_ff;
   logic [SYMW-1:0] idx_ff, cpi_ff;
   logic            cpv_ff, mode_ff, full_ff;
   logic [SYM_W-1:0] sym_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] pl_ff [ALPHABET];

   logic [TOTAL_W-1:0] rsp_total_ff, rsp_ending_ff;
   logic [NEW_W-1:0]   rsp_new_ff;
   logic               rsp_valid_ff, rsp_full_ff;

   logic [SYMW-1:0] sym_idx;
   logic            sym_ok, req_sym_ok, full_cond, t_zero, lk_zero, ll_match;
   logic [PW-1:0]   added;

   assign sym_idx    = SYMW'(sym_ff);
   assign sym_ok     = 32'(sym_ff) < ALPHABET;
   assign req_sym_ok = 32'(req_symbol) < ALPHABET;
   assign full_cond  = (plen_ff >= PW'(MAX_LEN)) || ((32'(sc_ff) + 2) >= NSTATES);
   assign t_zero     = (trans_rd_ff == '0);
   assign lk_zero    = (lk_rd_ff == '0);
   assign ll_match   = (ll_rd_ff == llp_ff + PW'(1));
   assign added      = llcur_ff - ll_rd_ff;

   // status to the controller
   assign status.mode     = mode_ff;
   assign status.sym_ok   = sym_ok;
   assign status.full     = full_ff;
   assign status.t_zero   = t_zero;
   assign status.lk_zero  = lk_zero;
   assign status.ll_match = ll_match;
   assign status.t_eq_q   = (trans_rd_ff == q_ff);
   assign status.idx_last = (idx_ff == SYMW'(ALPHABET - 1));
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // memory read addresses
   always_comb begin
      trans_ra = {p_ff, sym_idx};
      ll_ra    = p_ff;
      lk_ra    = p_ff;
      case (cmd.op)
         OP_COPY:      trans_ra = {q_ff, idx_ff};
         OP_NEW_STATE: ll_ra = last_ff;
         OP_Q_RD: begin
            ll_ra = q_ff;
            lk_ra = q_ff;
         end
         OP_FIN_RD:    ll_ra = lnkcur_ff;
         default: begin
         end
      endcase
   end

   // memory writes
   always_comb begin
      trans_we = 1'b0;
      trans_wa = {p_ff, sym_idx};
      trans_wd = cur_ff;
      ll_we    = 1'b0;
      ll_wa    = cur_ff;
      ll_wd    = ll_rd_ff + PW'(1);
      lk_we    = 1'b0;
      lk_wa    = cur_ff;
      lk_wd    = q_ff;
      if (cpv_ff) begin
         trans_we = 1'b1;
         trans_wa = {clone_ff, cpi_ff};
         trans_wd = trans_rd_ff;
      end
      case (cmd.op)
         OP_CLEAR_INIT: begin
            ll_we = 1'b1;
            ll_wa = SW'(1);
            ll_wd = '0;
            lk_we = 1'b1;
            lk_wa = SW'(1);
            lk_wd = '0;
         end
         OP_ROW_CLR: begin
            trans_we = 1'b1;
            trans_wa = {row_ff, idx_ff};
            trans_wd = '0;
         end
         OP_LLP: begin
            ll_we = 1'b1;
         end
         OP_WALK1_CK: begin
            trans_we = t_zero;
            lk_we    = t_zero && lk_zero;
            lk_wd    = SW'(1);
         end
         OP_Q_CK: begin
            lk_we = 1'b1;
            if (!ll_match) begin
               ll_we = 1'b1;
               ll_wa = sc_ff + SW'(1);
               ll_wd = llp_ff + PW'(1);
               lk_wa = sc_ff + SW'(1);
               lk_wd = lk_rd_ff;
            end
         end
         OP_LINKQ: begin
            lk_we = 1'b1;
            lk_wa = q_ff;
            lk_wd = clone_ff;
         end
         OP_LINKCUR: begin
            lk_we = 1'b1;
            lk_wd = clone_ff;
         end
         OP_WALK2_CK: begin
            trans_we = status.t_eq_q;
            trans_wd = clone_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_wa] <= trans_wd;
      end
      trans_rd_ff <= trans_mem[trans_ra];
   end

   always_ff @(posedge clock) begin
      if (ll_we) begin
         ll_mem[ll_wa] <= ll_wd;
      end
      ll_rd_ff <= ll_mem[ll_ra];
   end

   always_ff @(posedge clock) begin
      if (lk_we) begin
         lk_mem[lk_wa] <= lk_wd;
      end
      lk_rd_ff <= lk_mem[lk_ra];
   end

   // copy pipeline valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cpv_ff <= 1'b0;
      end else begin
         cpv_ff <= (cmd.op == OP_COPY);
      end
      cpi_ff <= idx_ff;
   end

   // walk registers and counters
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            mode_ff  <= req_mode;
            sym_ff   <= req_symbol;
            added_ff <= '0;
            full_ff  <= !req_mode && req_sym_ok && full_cond;
         end
         OP_CLEAR_INIT: begin
            sc_ff    <= SW'(1);
            last_ff  <= SW'(1);
            plen_ff  <= '0;
            total_ff <= '0;
            row_ff   <= SW'(1);
            idx_ff   <= '0;
            for (int i = 0; i < ALPHABET; i++) begin
               pl_ff[i] <= '0;
            end
         end
         OP_ROW_CLR: begin
            idx_ff <= idx_ff + SYMW'(1);
         end
         OP_NEW_STATE: begin
            cur_ff <= sc_ff + SW'(1);
            sc_ff  <= sc_ff + SW'(1);
            row_ff <= sc_ff + SW'(1);
            p_ff   <= last_ff;
            idx_ff <= '0;
         end
         OP_LLP: begin
            llp_ff   <= ll_rd_ff;
            llcur_ff <= ll_rd_ff + PW'(1);
         end
         OP_WALK1_CK: begin
            if (t_zero) begin
               p_ff <= lk_rd_ff;
               if (lk_zero) begin
                  lnkcur_ff <= SW'(1);
               end
            end else begin
               q_ff   <= trans_rd_ff;
               llp_ff <= ll_rd_ff;
            end
         end
         OP_Q_CK: begin
            if (ll_match) begin
               lnkcur_ff <= q_ff;
            end else begin
               clone_ff <= sc_ff + SW'(1);
               sc_ff    <= sc_ff + SW'(1);
               idx_ff   <= '0;
            end
         end
         OP_COPY: begin
            idx_ff <= idx_ff + SYMW'(1);
         end
         OP_LINKCUR: begin
            lnkcur_ff <= clone_ff;
         end
         OP_WALK2_CK: begin
            if (status.t_eq_q) begin
               p_ff <= lk_rd_ff;
            end
         end
         OP_FIN_RD: begin
            last_ff <= cur_ff;
            plen_ff <= plen_ff + PW'(1);
         end
         OP_FIN_CK: begin
            added_ff       <= added;
            total_ff       <= total_ff + TOTAL_W'(added);
            pl_ff[sym_idx] <= pl_ff[sym_idx] + TOTAL_W'(added);
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_OUT) begin
         rsp_total_ff  <= total_ff;
         rsp_new_ff    <= NEW_W'(added_ff);
         rsp_ending_ff <= (sym_ok && !mode_ff) ? pl_ff[sym_idx] : '0;
         rsp_full_ff   <= full_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_total  = rsp_total_ff;
   assign rsp_new    = rsp_new_ff;
   assign rsp_ending = rsp_ending_ff;
   assign rsp_full   = rsp_full_ff;
endmodule

[hdl/suffix_automaton_distinct_substrings.sv]
// online suffix automaton with distinct-substring counts, one letter a request
// an append makes the new state, sets its length, clears its row and walks the links;
// a walk stopped on a transition reads q, and a split copies q's row, relinks q and
// the new state and walks again; a clear resets the root; one request at a time, the
// next taken the cycle after the result is loaded, which waits while the previous result
// is held; synchronous active-high reset, then the root row is cleared
`include "suffix_automaton_distinct_substrings_defines.svh"
module suffix_automaton_distinct_substrings #(
   parameter int MAX_LEN  = sad_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = sad_pkg::ALPHABET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] symbol, rest zero
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [19:0] total_distinct, [30:20] new_distinct,
                                    // [50:31] ending_with_letter, rest zero
   output logic        rsp_tuser    // [0] full_res
);
   import sad_pkg::*;

   sad_cmd_type    cmd;
   sad_status_type status;
   logic [TOTAL_W-1:0] total, ending;
   logic [NEW_W-1:0]   new_cnt;

   sad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sad_datapath #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_mode   (req_tuser),
      .req_symbol (req_tdata[SYM_W-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_total  (total),
      .rsp_new    (new_cnt),
      .rsp_ending (ending),
      .rsp_full   (rsp_tuser)
   );

   assign rsp_tdata = {5'd0, ending, new_cnt, total};

   // one request in flight: no new request right after one is taken
   `SAD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // a dropped letter adds nothing
   `SAD_ASSERT_NOW(a_full_adds_none, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[30:20] == '0)
   // added substrings show in the total and in the ending count
   `SAD_ASSERT_NOW(a_new_in_total, clock, reset, rsp_tvalid && (rsp_tdata[30:20] != '0),
      (rsp_tdata[19:0] != '0) && (rsp_tdata[50:31] != '0))
endmodule

[dv/tb.sv]
// testbench for the online suffix automaton with distinct-substring counts
// depends on sad_pkg and suffix_automaton_distinct_substrings
module tb;
   import sad_pkg::*;

   localparam int MAXL = MAX_LEN_DEF;
   localparam int ALPH = ALPHABET_DEF;
   localparam int NST  = 2 * MAXL + 2;
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [NEW_W-1:0]   added;
      logic [TOTAL_W-1:0] ending;
      logic               full;
   } count_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [4:0] symbol, rest zero
   logic        req_tuser;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // [19:0] total, [30:20] new, [50:31] ending, rest zero
   logic        rsp_tuser;    // [0] full_res

   suffix_automaton_distinct_substrings uut (.*);

   // automaton mirror
   int unsigned trans [NST][ALPH];
   int unsigned maxlen [NST];
   int unsigned slink [NST];
   int unsigned last_st, n_states, text_len, distinct_sum;
   int unsigned letter_sum [ALPH];

   count_rsp_type expected_q [$];
   int errors = 0;
   int cycles = 0;
   int rsp_wait = 0;
   bit stall_rsp = 1;

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic void wipe_automaton();
      foreach (trans[i, j]) trans[i][j] = 0;
      foreach (maxlen[i]) begin
         maxlen[i] = 0;
         slink[i] = 0;
      end
      foreach (letter_sum[i]) letter_sum[i] = 0;
      last_st = 1; n_states = 1; text_len = 0; distinct_sum = 0;
   endfunction

   function automatic int unsigned extend_automaton(int unsigned sym);
      int unsigned p, cur, q, cl;
      p = last_st;
      n_states++;
      cur = n_states;
      maxlen[cur] = maxlen[p] + 1;
      while (p != 0 && trans[p][sym] == 0) begin
         trans[p][sym] = cur;
         p = slink[p];
      end
      if (p == 0) slink[cur] = 1;
      else begin
         q = trans[p][sym];
         if (maxlen[q] == maxlen[p] + 1) slink[cur] = q;
         else begin
            n_states++;
            cl = n_states;
            maxlen[cl] = maxlen[p] + 1;
            for (int k = 0; k < ALPH; k++) trans[cl][k] = trans[q][k];
            slink[cl] = slink[q];
            slink[q] = cl;
            slink[cur] = cl;
            while (p != 0 && trans[p][sym] == q) begin
               trans[p][sym] = cl;
               p = slink[p];
            end
         end
      end
      last_st = cur;
      text_len++;
      return maxlen[cur] - maxlen[slink[cur]];
   endfunction

   function automatic count_rsp_type predict_counts(logic mode, logic [4:0] sym);
      count_rsp_type r;
      int unsigned added = 0, ending = 0, full = 0;
      if (mode == MODE_CLEAR) begin
         wipe_automaton();
         return '0;
      end
      if (sym < ALPH) begin
         if (text_len >= MAXL || n_states + 2 >= NST) full = 1;
         else begin
            added = extend_automaton(sym);
            distinct_sum += added;
            letter_sum[sym] += added;
         end
         ending = letter_sum[sym];
      end
      r.total = distinct_sum[TOTAL_W-1:0];
      r.added = added[NEW_W-1:0];
      r.ending = ending[TOTAL_W-1:0];
      r.full = full[0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // send one request, prediction made at acceptance; valid stays up only
   // when the next request follows with no gap
   task automatic send_request(logic mode, logic [4:0] sym);
      int gap;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sym};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.insert(expected_q.size(), predict_counts(mode, sym));
   endtask

   // no further request offered
   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   // response ready after a drawn wait for every response while stall_rsp is set
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = stall_rsp ? $urandom_range(0, 15) : 0;
         rsp_wait   <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait != 0) begin
         if (rsp_tvalid) rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      count_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            want = expected_q.pop_front();
            if (rsp_tdata[19:0] != want.total)
               report_mismatch("total", rsp_tdata[19:0], want.total);
            if (rsp_tdata[30:20] != want.added)
               report_mismatch("new", rsp_tdata[30:20], want.added);
            if (rsp_tdata[50:31] != want.ending)
               report_mismatch("ending", rsp_tdata[50:31], want.ending);
            if (rsp_tdata[55:51] != 0) report_mismatch("pad", rsp_tdata[55:51], 0);
            if (rsp_tuser != want.full) report_mismatch("full", rsp_tuser, want.full);
         end
      end
   end

   task automatic drain_responses();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // extremes, clear, out-of-range symbols and a split-heavy string
   task automatic test_directed();
      logic [4:0] s [12] = '{0, 25, 0, 25, 0, 0, 1, 26, 31, 0, 1, 0};
      foreach (s[i]) send_request(MODE_APPEND, s[i]);
      send_request(MODE_CLEAR, 5'd31);
      send_request(MODE_APPEND, 5'd30);
      send_request(MODE_APPEND, 5'd2);
      send_request(MODE_APPEND, 5'd1);
      send_request(MODE_APPEND, 5'd2);
      send_request(MODE_CLEAR, 5'd0);
   endtask

   // random strings over small and full alphabets, rare clears and bad symbols
   task automatic test_random(int n);
      int unsigned span;
      span = 2;
      for (int i = 0; i < n; i++) begin
         if (i % 97 == 0) span = $urandom_range(1, ALPH);
         case ($urandom_range(0, 99))
            0: send_request(MODE_CLEAR, 5'($urandom_range(0, 31)));
            1, 2: send_request(MODE_APPEND, 5'($urandom_range(ALPH, 31)));
            default: send_request(MODE_APPEND, 5'($urandom_range(0, span - 1)));
         endcase
      end
   endtask

   // fill to capacity, then letters are dropped
   task automatic test_capacity();
      send_request(MODE_CLEAR, 5'd0);
      for (int i = 0; i < MAXL + 12; i++)
         send_request(MODE_APPEND, 5'($urandom_range(0, 3)));
      send_request(MODE_APPEND, 5'd25);
      send_request(MODE_APPEND, 5'd31);
      send_request(MODE_CLEAR, 5'd0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      wipe_automaton();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      // hold off until everything is back
      stop_requests();
      drain_responses();
      stall_rsp = 0;
      test_random(200);
      stall_rsp = 1;
      test_random(300);
      test_capacity();
      stop_requests();
      drain_responses();
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule
